// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |-> (rhs)) \
		else $error("assertion failed: implication does not hold");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |=> (rhs)) \
		else $error("assertion failed: next-cycle implication does not hold");

`endif

// ===== rtl/ccb_pkg.sv =====
// Package of the C comment and literal blanker: payload types and character codes.
`default_nettype none

package ccb_pkg;

	// Character codes the lexer looks at or emits.
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Lexical modes.
	localparam logic [2:0] MODE_NORMAL = 3'd0;
	localparam logic [2:0] MODE_LINE   = 3'd1;
	localparam logic [2:0] MODE_BLOCK  = 3'd2;
	localparam logic [2:0] MODE_CHAR   = 3'd3;
	localparam logic [2:0] MODE_STRING = 3'd4;

	// Input request payload.
	typedef struct packed {
		logic [7:0] text_byte;
		logic       final_byte;
	} in_item_t;

	// Output request payload.
	typedef struct packed {
		logic [7:0] out_char;
		logic       has_char;
		logic       end_of_text;
	} out_item_t;

endpackage

`default_nettype wire

// ===== rtl/c_comment_and_literal_blanker.sv =====
// C comment and literal blanker, top level.
// Pipeline: a request accepted into the input stage is classified there, and its results are
// written into the result buffer once they fit; the head slot of that buffer drives the output.
// Throughput: one input request per cycle unless the output stalls; the single output port
// sends one result per cycle, so a request that yields two makes the next such request wait.
// Reset (arst_n low, asynchronous): normal code mode, no held slash or star, no escape,
// both buffers empty, blank_q set to 1.
`default_nettype none

module c_comment_and_literal_blanker (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  ccb_pkg::in_item_t  in_data,
	output logic             out_valid,
	input  wire              out_ready,
	output ccb_pkg::out_item_t out_data,
	input  wire              cfg_valid,
	output logic             cfg_ready,
	input  wire              cfg_data
);

	// Configuration register: 1 blanks the bodies of string literals.
	logic blank_q;

	// Input stage: one request waits here to be classified.
	ccb_pkg::in_item_t in_s1;
	logic              vld_s1;

	// Lexer state.
	logic [2:0] mode_q, mode_d;
	logic       esc_q, esc_d;
	logic       slash_q, slash_d;
	logic       star_q, star_d;

	// Result buffer: two slots, slot 0 is the head shown on the output.
	ccb_pkg::out_item_t res_q [2];
	ccb_pkg::out_item_t res_d [2];
	logic [1:0]         cnt_q, cnt_d;

	// Classification of the byte in the input stage.
	logic [7:0] c;
	logic       last;
	logic [7:0] em [2];
	logic [1:0] em_cnt;
	logic [1:0] nres;
	ccb_pkg::out_item_t r0, r1;

	logic       pop;
	logic [1:0] cnt_base;
	logic       advance;

	// Never stalls; the user must send writes only while the block is idle (unchecked).
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_q <= 1'b1;
		end else if (cfg_valid) begin
			blank_q <= cfg_data;
		end
	end

	// Output side: the head slot is the output register.
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = res_q[0];
	assign pop       = out_valid && out_ready;
	assign cnt_base  = cnt_q - {1'b0, pop};

	// The staged request moves on only when every result it causes fits in the buffer.
	assign advance  = vld_s1 && (({1'b0, cnt_base} + {1'b0, nres}) <= 3'd2);
	assign in_ready = !vld_s1 || advance;

	// Lexer: one pass over the staged byte gives up to two emitted characters and the
	// next state. The held slash and held star give the one byte of lookahead.
	always_comb begin
		c       = in_s1.text_byte;
		last    = in_s1.final_byte;
		mode_d  = mode_q;
		esc_d   = esc_q;
		slash_d = slash_q;
		star_d  = star_q;
		em[0]   = 8'd0;
		em[1]   = 8'd0;
		em_cnt  = 2'd0;
		case (mode_q)
			ccb_pkg::MODE_LINE: begin
				// Line comment: spaces up to the newline, which is kept.
				if (c == ccb_pkg::CH_NL) begin
					em[0]  = ccb_pkg::CH_NL;
					mode_d = ccb_pkg::MODE_NORMAL;
				end else begin
					em[0] = ccb_pkg::CH_SPACE;
				end
				em_cnt = 2'd1;
			end
			ccb_pkg::MODE_BLOCK: begin
				if (star_q && c == ccb_pkg::CH_SLASH) begin
					// Closing marker emits nothing.
					star_d = 1'b0;
					mode_d = ccb_pkg::MODE_NORMAL;
				end else begin
					// A held star not followed by a slash becomes a space first.
					if (star_q) begin
						em[0]  = ccb_pkg::CH_SPACE;
						em_cnt = 2'd1;
					end
					star_d = 1'b0;
					if (c == ccb_pkg::CH_STAR && !last) begin
						star_d = 1'b1;
					end else begin
						em[em_cnt[0]] = (c == ccb_pkg::CH_NL) ? ccb_pkg::CH_NL
						                                      : ccb_pkg::CH_SPACE;
						em_cnt = em_cnt + 2'd1;
					end
				end
			end
			ccb_pkg::MODE_CHAR: begin
				// Character literal passes unchanged; a backslash escapes the next byte.
				em[0]  = c;
				em_cnt = 2'd1;
				if (esc_q) begin
					esc_d = 1'b0;
				end else if (c == ccb_pkg::CH_BSL) begin
					esc_d = 1'b1;
				end else if (c == ccb_pkg::CH_APOS) begin
					mode_d = ccb_pkg::MODE_NORMAL;
				end
			end
			ccb_pkg::MODE_STRING: begin
				em_cnt = 2'd1;
				if (esc_q) begin
					esc_d = 1'b0;
					em[0] = blank_q ? ccb_pkg::CH_SPACE : c;
				end else if (c == ccb_pkg::CH_BSL) begin
					esc_d = 1'b1;
					em[0] = blank_q ? ccb_pkg::CH_SPACE : c;
				end else if (c == ccb_pkg::CH_QUOTE) begin
					em[0]  = c;
					mode_d = ccb_pkg::MODE_NORMAL;
				end else if (blank_q) begin
					em[0] = (c == ccb_pkg::CH_NL) ? ccb_pkg::CH_NL : ccb_pkg::CH_SPACE;
				end else begin
					em[0] = c;
				end
			end
			default: begin
				// Normal code; unused mode codes are treated the same way.
				mode_d  = ccb_pkg::MODE_NORMAL;
				slash_d = 1'b0;
				if (slash_q && c == ccb_pkg::CH_STAR) begin
					mode_d = ccb_pkg::MODE_BLOCK;
				end else if (slash_q && c == ccb_pkg::CH_SLASH) begin
					// Both slashes of a line comment become spaces.
					em[0]  = ccb_pkg::CH_SPACE;
					em[1]  = ccb_pkg::CH_SPACE;
					em_cnt = 2'd2;
					mode_d = ccb_pkg::MODE_LINE;
				end else begin
					// A held slash that opens no comment is released first.
					if (slash_q) begin
						em[0]  = ccb_pkg::CH_SLASH;
						em_cnt = 2'd1;
					end
					if (c == ccb_pkg::CH_SLASH && !last) begin
						slash_d = 1'b1;
					end else begin
						em[em_cnt[0]] = c;
						em_cnt = em_cnt + 2'd1;
						if (c == ccb_pkg::CH_APOS) begin
							mode_d = ccb_pkg::MODE_CHAR;
						end else if (c == ccb_pkg::CH_QUOTE) begin
							mode_d = ccb_pkg::MODE_STRING;
						end
					end
				end
			end
		endcase
		// The last byte of a text returns the lexer to its reset state.
		if (last) begin
			mode_d  = ccb_pkg::MODE_NORMAL;
			esc_d   = 1'b0;
			slash_d = 1'b0;
			star_d  = 1'b0;
		end
	end

	// Result requests: a final byte that emits nothing still sends an end marker.
	always_comb begin
		r0 = '{out_char: em[0], has_char: 1'b1, end_of_text: last && (em_cnt == 2'd1)};
		r1 = '{out_char: em[1], has_char: 1'b1, end_of_text: last};
		nres = em_cnt;
		if (em_cnt == 2'd0) begin
			r0   = '{out_char: 8'd0, has_char: 1'b0, end_of_text: 1'b1};
			nres = {1'b0, last};
		end
	end

	// Next contents of the result buffer: shift on a pop, then append behind what is left.
	always_comb begin
		res_d[0] = res_q[0];
		res_d[1] = res_q[1];
		if (pop) begin
			res_d[0] = res_q[1];
		end
		if (advance && nres != 2'd0) begin
			res_d[cnt_base[0]] = r0;
			if (nres == 2'd2) begin
				res_d[1] = r1;
			end
		end
		cnt_d = cnt_base + (advance ? nres : 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			mode_q  <= ccb_pkg::MODE_NORMAL;
			esc_q   <= 1'b0;
			slash_q <= 1'b0;
			star_q  <= 1'b0;
			cnt_q   <= 2'd0;
		end else begin
			cnt_q <= cnt_d;
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (advance) begin
				mode_q  <= mode_d;
				esc_q   <= esc_d;
				slash_q <= slash_d;
				star_q  <= star_d;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_data;
		end
		res_q[0] <= res_d[0];
		res_q[1] <= res_d[1];
	end

endmodule

`default_nettype wire

// ===== rtl/ccb_checker.sv =====
// Port-level checker for the C comment and literal blanker, with its bind statement.
`default_nettype none
`include "assert_macros.svh"

module ccb_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                in_ready,
	input wire                out_valid,
	input wire                out_ready,
	input ccb_pkg::out_item_t out_data
);

	// A stalled result request holds its payload.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	// A result without a character is only ever the end marker.
	`ASSERT_IMPLIES(a_marker_end, clk, arst_n, out_valid && !out_data.has_char, out_data.end_of_text)
	// The end marker carries a zero character.
	`ASSERT_IMPLIES(a_marker_zero, clk, arst_n, out_valid && !out_data.has_char, !(|out_data.out_char))
	// With no result pending, the input side is never stalled.
	`ASSERT_IMPLIES(a_empty_ready, clk, arst_n, !out_valid, in_ready)

endmodule

bind c_comment_and_literal_blanker ccb_checker u_ccb_checker (.*);

`default_nettype wire

// ===== verif/c_comment_and_literal_blanker_tb.sv =====
// Self-checking testbench of the C comment and literal blanker, with its scoreboard class.
`timescale 1ns / 100ps

// Tracks the lexer state of the text stream and holds the bytes the block must emit next.
class blanked_text_board;
	logic [2:0]         mode;
	bit                 esc;
	bit                 held_slash;
	bit                 held_star;
	bit                 blank;
	ccb_pkg::out_item_t expected_chars[$];
	logic [7:0]         staged[$];
	int                 err_count;
	int                 result_count;
	int                 byte_count;
	int                 text_count;

	function new();
		mode = ccb_pkg::MODE_NORMAL;
		esc = 0;
		held_slash = 0;
		held_star = 0;
		blank = 1;
		err_count = 0;
		result_count = 0;
		byte_count = 0;
		text_count = 0;
	endfunction

	function void set_blank(logic v);
		blank = v;
	endfunction

	function int pending();
		return expected_chars.size();
	endfunction

	// Appends one byte to those the current request emits.
	function void stage(logic [7:0] c);
		staged.insert(staged.size(), c);
	endfunction

	// A byte of ordinary code, after any held slash has been dealt with.
	function void code_byte(logic [7:0] c, bit last);
		if (c == ccb_pkg::CH_SLASH) begin
			if (last)
				stage(ccb_pkg::CH_SLASH);
			else
				held_slash = 1;
		end else begin
			stage(c);
			if (c == ccb_pkg::CH_APOS)
				mode = ccb_pkg::MODE_CHAR;
			else if (c == ccb_pkg::CH_QUOTE)
				mode = ccb_pkg::MODE_STRING;
		end
	endfunction

	// A byte inside a block comment, after any held star has been dealt with.
	function void comment_byte(logic [7:0] c, bit last);
		if (c == ccb_pkg::CH_STAR && !last)
			held_star = 1;
		else
			stage((c == ccb_pkg::CH_NL) ? ccb_pkg::CH_NL : ccb_pkg::CH_SPACE);
	endfunction

	function void note_request(ccb_pkg::in_item_t req);
		logic [7:0]         c;
		bit                 last;
		ccb_pkg::out_item_t r;
		int                 k;
		c = req.text_byte;
		last = req.final_byte;
		byte_count++;
		staged.delete();
		case (mode)
			ccb_pkg::MODE_LINE: begin
				stage((c == ccb_pkg::CH_NL) ? ccb_pkg::CH_NL : ccb_pkg::CH_SPACE);
				if (c == ccb_pkg::CH_NL)
					mode = ccb_pkg::MODE_NORMAL;
			end
			ccb_pkg::MODE_BLOCK: begin
				if (held_star) begin
					held_star = 0;
					if (c == ccb_pkg::CH_SLASH) begin
						mode = ccb_pkg::MODE_NORMAL;
					end else begin
						stage(ccb_pkg::CH_SPACE);
						comment_byte(c, last);
					end
				end else begin
					comment_byte(c, last);
				end
			end
			ccb_pkg::MODE_CHAR: begin
				stage(c);
				if (esc)
					esc = 0;
				else if (c == ccb_pkg::CH_BSL)
					esc = 1;
				else if (c == ccb_pkg::CH_APOS)
					mode = ccb_pkg::MODE_NORMAL;
			end
			ccb_pkg::MODE_STRING: begin
				if (esc) begin
					esc = 0;
					stage(blank ? ccb_pkg::CH_SPACE : c);
				end else if (c == ccb_pkg::CH_BSL) begin
					esc = 1;
					stage(blank ? ccb_pkg::CH_SPACE : c);
				end else if (c == ccb_pkg::CH_QUOTE) begin
					stage(c);
					mode = ccb_pkg::MODE_NORMAL;
				end else if (blank && c != ccb_pkg::CH_NL) begin
					stage(ccb_pkg::CH_SPACE);
				end else begin
					stage(c);
				end
			end
			default: begin
				mode = ccb_pkg::MODE_NORMAL;
				if (held_slash) begin
					held_slash = 0;
					if (c == ccb_pkg::CH_STAR) begin
						mode = ccb_pkg::MODE_BLOCK;
					end else if (c == ccb_pkg::CH_SLASH) begin
						stage(ccb_pkg::CH_SPACE);
						stage(ccb_pkg::CH_SPACE);
						mode = ccb_pkg::MODE_LINE;
					end else begin
						stage(ccb_pkg::CH_SLASH);
						code_byte(c, last);
					end
				end else begin
					code_byte(c, last);
				end
			end
		endcase
		if (last) begin
			mode = ccb_pkg::MODE_NORMAL;
			esc = 0;
			held_slash = 0;
			held_star = 0;
			text_count++;
		end
		if (last && staged.size() == 0) begin
			r.out_char = 8'h00;
			r.has_char = 1'b0;
			r.end_of_text = 1'b1;
			expected_chars.insert(expected_chars.size(), r);
		end else begin
			for (k = 0; k < staged.size(); k++) begin
				r.out_char = staged[k];
				r.has_char = 1'b1;
				r.end_of_text = last && (k == staged.size() - 1);
				expected_chars.insert(expected_chars.size(), r);
			end
		end
	endfunction

	function void check_result(ccb_pkg::out_item_t got);
		ccb_pkg::out_item_t want;
		if (expected_chars.size() == 0) begin
			$error("unexpected result: out_char %h has_char %b end_of_text %b",
				got.out_char, got.has_char, got.end_of_text);
			err_count++;
			return;
		end
		want = expected_chars.pop_front();
		result_count++;
		if (got.out_char !== want.out_char) begin
			$error("out_char: expected %h, got %h", want.out_char, got.out_char);
			err_count++;
		end
		if (got.has_char !== want.has_char) begin
			$error("has_char: expected %b, got %b", want.has_char, got.has_char);
			err_count++;
		end
		if (got.end_of_text !== want.end_of_text) begin
			$error("end_of_text: expected %b, got %b", want.end_of_text, got.end_of_text);
			err_count++;
		end
	endfunction
endclass

module c_comment_and_literal_blanker_tb;

	// The run is cut off here; a correct run needs a small fraction of it.
	localparam int CYCLE_LIMIT = 200000;
	// Cycles allowed after the last expected result, covering the input stage and the result buffer.
	localparam int SETTLE_CYCLES = 6;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	ccb_pkg::in_item_t  in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	ccb_pkg::out_item_t out_data;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic               cfg_data = 1'b0;

	// Stall odds in percent, per receiver cycle and per sent request; zero gives full rate.
	int        stall_pct = 24;
	int        cycle_count = 0;
	// Bytes of the token being generated for the random part.
	logic [7:0] token_bytes[$];

	blanked_text_board sb;

	c_comment_and_literal_blanker i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("simulation failed");
		$finish;
	end

	// The receiver holds off at random; the decision is made at the falling edge so the
	// block sees a stable ready at the next rising edge.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Every handshake is observed at the rising edge, before the block updates its outputs.
	// Each accepted input request is predicted at once, so its results are always queued
	// ahead of their arrival.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_request(in_data);
			if (out_valid && out_ready)
				sb.check_result(out_data);
			if (cfg_valid && cfg_ready)
				sb.set_blank(cfg_data);
		end
	end

	// Offers one input request, maybe after a short random gap, and returns at the edge
	// where it is taken. Valid stays high between back-to-back requests.
	task automatic push_byte(ccb_pkg::in_item_t req);
		@(negedge clk);
		if ($urandom_range(0, 99) < stall_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (!in_ready);
	endtask

	// Sends a string of text, flagging its last byte as the end of the text when asked.
	task automatic send_text(string s, bit ends);
		ccb_pkg::in_item_t req;
		int                i;
		for (i = 0; i < s.len(); i++) begin
			req.text_byte = s[i];
			req.final_byte = ends && (i == s.len() - 1);
			push_byte(req);
		end
	endtask

	// The sender stops until every expected result has come out, then allows for a request
	// that produced nothing and may still be in flight.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the string blanking register; only called while the block is idle.
	task automatic write_blank(bit v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick(string pool);
		return pool[$urandom_range(0, pool.len() - 1)];
	endfunction

	// Appends one byte to the token being built.
	function automatic void add_token_byte(logic [7:0] b);
		token_bytes.insert(token_bytes.size(), b);
	endfunction

	// Builds one C-like token in token_bytes: runs of code or white space, comments and
	// literals with random bodies, a lone slash or star before code, or raw noise bytes.
	task automatic rand_token();
		int    kind;
		int    n;
		int    j;
		string code_pool;
		string text_pool;
		string lit_pool;
		code_pool = "abz_09 ;(+=\n";
		text_pool = "ab_9 ;*/\n\\'\"";
		lit_pool = "abz 09*/;\n'";
		kind = $urandom_range(0, 99);
		n = $urandom_range(0, 6);
		if (kind < 25) begin
			for (j = 0; j <= n; j++) add_token_byte(pick(code_pool));
		end else if (kind < 35) begin
			for (j = 0; j <= n; j++) add_token_byte(pick(" \n\t"));
		end else if (kind < 45) begin
			add_token_byte(ccb_pkg::CH_SLASH);
			add_token_byte(ccb_pkg::CH_SLASH);
			for (j = 0; j < n; j++) add_token_byte(pick(text_pool));
			add_token_byte(ccb_pkg::CH_NL);
		end else if (kind < 57) begin
			add_token_byte(ccb_pkg::CH_SLASH);
			add_token_byte(ccb_pkg::CH_STAR);
			for (j = 0; j < n; j++) add_token_byte(pick(text_pool));
			add_token_byte(ccb_pkg::CH_STAR);
			if ($urandom_range(0, 2) == 0)
				add_token_byte(ccb_pkg::CH_STAR);
			add_token_byte(ccb_pkg::CH_SLASH);
		end else if (kind < 67) begin
			add_token_byte(ccb_pkg::CH_APOS);
			if ($urandom_range(0, 2) == 0) begin
				add_token_byte(ccb_pkg::CH_BSL);
				add_token_byte(pick(text_pool));
			end else begin
				add_token_byte(pick(code_pool));
			end
			add_token_byte(ccb_pkg::CH_APOS);
		end else if (kind < 79) begin
			add_token_byte(ccb_pkg::CH_QUOTE);
			for (j = 0; j < n; j++) begin
				if ($urandom_range(0, 3) == 0) begin
					add_token_byte(ccb_pkg::CH_BSL);
					add_token_byte(pick(text_pool));
				end else begin
					add_token_byte(pick(lit_pool));
				end
			end
			add_token_byte(ccb_pkg::CH_QUOTE);
		end else if (kind < 90) begin
			// A lone slash or star in code, such as a division or a dereference.
			add_token_byte(pick("/*"));
			add_token_byte(pick(code_pool));
		end else begin
			for (j = 0; j <= n; j++) add_token_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// Random text: texts end after about a dozen tokens, and now and then a stray end
	// flag cuts a comment or literal short.
	task automatic random_phase(int n_items);
		int                sent;
		int                k;
		bit                end_here;
		ccb_pkg::in_item_t req;
		sent = 0;
		while (sent < n_items) begin
			token_bytes.delete();
			rand_token();
			end_here = ($urandom_range(0, 11) == 0);
			for (k = 0; k < token_bytes.size(); k++) begin
				req.text_byte = token_bytes[k];
				req.final_byte = (end_here && k == token_bytes.size() - 1) ||
					($urandom_range(0, 99) < 2);
				push_byte(req);
			end
			sent += token_bytes.size();
		end
	endtask

	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, with the register at its reset value of 1.
		push_byte({8'h00, 1'b0});
		// Held slash followed by another byte, the highest byte value, at the end of text.
		send_text("/", 1'b0);
		push_byte({8'hFF, 1'b1});
		// Slash as the last byte has no lookahead and comes out as itself.
		send_text("/", 1'b1);
		// Star as the last byte inside a block comment comes out as a space.
		send_text("/**", 1'b1);
		// An opening marker alone as the end of text yields only the end marker.
		send_text("/*", 1'b1);
		send_text("//a\n", 1'b0);
		// Held star followed by another star, then the closing slash.
		send_text("/*x**/", 1'b0);
		send_text("'\\''", 1'b0);
		// Escaped quote and bare newline in a string closed by the last byte of the text.
		send_text("\"\\\"\n\"", 1'b1);
		drain();

		// Random part, in phases with the register at both values. The second phase runs
		// with neither side stalling.
		write_blank(1'b0);
		random_phase(300);
		drain();
		write_blank(1'b1);
		stall_pct = 0;
		random_phase(300);
		drain();
		stall_pct = 24;
		write_blank(1'b0);
		random_phase(300);
		drain();
		write_blank(1'b1);
		random_phase(330);

		drain();
		$display("Run covered %0d input bytes in %0d texts and checked %0d results,",
			sb.byte_count, sb.text_count, sb.result_count);
		$display("with string blanking both on and off and with and without back-pressure.");
		if (sb.err_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
